/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the bytecode executor.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge, held off while reset is low.
`define SBE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define SBE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define SBE_ASSERT(lbl, prop, msg)
`define SBE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/sbe_pkg.sv */
// Shared widths, opcodes, status codes and register indexes of the executor.
// No dependencies.
`timescale 1ns / 1ps
package sbe_pkg;
    localparam int STACK_WORDS_DEF  = 1024;
    localparam int GLOBAL_WORDS_DEF = 256;
    localparam int CODE_WORDS_DEF   = 4096;

    localparam int W_WORD   = 32;
    localparam int W_ACTION = 8;
    localparam int W_ARGC   = 10;
    localparam int W_ADDR   = 12;
    localparam int W_PLEN   = 13;
    localparam int W_STATUS = 3;

    localparam logic [W_PLEN-1:0] PLEN_RESET = 13'd4096;

    localparam logic [W_ACTION-1:0] OP_IADD   = 8'd1;
    localparam logic [W_ACTION-1:0] OP_ISUB   = 8'd2;
    localparam logic [W_ACTION-1:0] OP_IMUL   = 8'd3;
    localparam logic [W_ACTION-1:0] OP_ILT    = 8'd4;
    localparam logic [W_ACTION-1:0] OP_IEQ    = 8'd5;
    localparam logic [W_ACTION-1:0] OP_BR     = 8'd6;
    localparam logic [W_ACTION-1:0] OP_BRT    = 8'd7;
    localparam logic [W_ACTION-1:0] OP_BRF    = 8'd8;
    localparam logic [W_ACTION-1:0] OP_ICONST = 8'd9;
    localparam logic [W_ACTION-1:0] OP_LOAD   = 8'd10;
    localparam logic [W_ACTION-1:0] OP_GLOAD  = 8'd11;
    localparam logic [W_ACTION-1:0] OP_STORE  = 8'd12;
    localparam logic [W_ACTION-1:0] OP_GSTORE = 8'd13;
    localparam logic [W_ACTION-1:0] OP_PRINT  = 8'd14;
    localparam logic [W_ACTION-1:0] OP_POP    = 8'd15;
    localparam logic [W_ACTION-1:0] OP_HALT   = 8'd16;
    localparam logic [W_ACTION-1:0] OP_CALL   = 8'd17;
    localparam logic [W_ACTION-1:0] OP_RET    = 8'd18;
    localparam logic [W_ACTION-1:0] OP_INIT   = 8'd19;

    localparam logic [W_STATUS-1:0] ST_OK    = 3'd0;
    localparam logic [W_STATUS-1:0] ST_BADOP = 3'd1;
    localparam logic [W_STATUS-1:0] ST_OVER  = 3'd2;
    localparam logic [W_STATUS-1:0] ST_UNDER = 3'd3;
    localparam logic [W_STATUS-1:0] ST_GADDR = 3'd4;
    localparam logic [W_STATUS-1:0] ST_SLOT  = 3'd5;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_PLEN  = 1'b1;
endpackage

/* hw/rtl/sbe_if.sv */
// Valid/ready channels for instruction beats and result beats.
// Depends on sbe_pkg for field widths.
`timescale 1ns / 1ps
interface sbe_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [sbe_pkg::W_ACTION-1:0]        action;
    logic signed [sbe_pkg::W_WORD-1:0]   first_operand;
    logic [sbe_pkg::W_ARGC-1:0]          second_operand;
    modport source (output valid, action, first_operand, second_operand, input ready);
    modport sink   (input valid, action, first_operand, second_operand, output ready);
endinterface

interface sbe_res_if;
    logic                                valid;
    logic                                ready;
    logic [sbe_pkg::W_ADDR-1:0]          next_address;
    logic                                print_valid;
    logic signed [sbe_pkg::W_WORD-1:0]   print_value;
    logic                                halted;
    logic [sbe_pkg::W_STATUS-1:0]        status;
    modport source (output valid, next_address, print_valid, print_value, halted, status,
                    input ready);
    modport sink   (input valid, next_address, print_valid, print_value, halted, status,
                    output ready);
endinterface

/* hw/rtl/sbe_stack_mem.sv */
// Operand and call stack store: one write port, one registered read port.
// Depends on sbe_pkg for the word width.
`timescale 1ns / 1ps
module sbe_stack_mem #(
    parameter int DEPTH = sbe_pkg::STACK_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [$clog2(DEPTH)-1:0]          i_waddr,
    input  logic [sbe_pkg::W_WORD-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0]          i_raddr,
    output logic [sbe_pkg::W_WORD-1:0]        o_rdata
);
    logic [sbe_pkg::W_WORD-1:0] r_mem [DEPTH];
    logic [sbe_pkg::W_WORD-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/sbe_global_mem.sv */
// Global data store with per-entry valid bits; an unwritten entry reads zero.
// Depends on sbe_pkg for the word width.
`timescale 1ns / 1ps
module sbe_global_mem #(
    parameter int DEPTH = sbe_pkg::GLOBAL_WORDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_addr,
    input  logic [sbe_pkg::W_WORD-1:0]    i_wdata,
    output logic [sbe_pkg::W_WORD-1:0]    o_rdata
);
    logic [sbe_pkg::W_WORD-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_valid;
    logic [sbe_pkg::W_WORD-1:0] r_rdata;
    logic                       r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    // Valid bits stand in for a clearing pass at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_addr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;
endmodule

/* hw/rtl/stack_bytecode_executor.sv */
// Stack bytecode executor: one instruction beat in, one result beat out.
// Sequence: idle takes the beat, the read state issues its stack reads (none, one,
// two for arithmetic, four for ret), execute registers the result beat; a beat taken
// while halted or past the end is answered from idle. A new beat is taken only in idle
// with the result slot free or being taken; call also runs W1, W2 for two more stack writes.
// Reset (synchronous, active low): empty stack, frame -1, pointer 0, length 4096, halt clear.
`timescale 1ns / 1ps
module stack_bytecode_executor #(
    parameter int STACK_WORDS  = sbe_pkg::STACK_WORDS_DEF,
    parameter int GLOBAL_WORDS = sbe_pkg::GLOBAL_WORDS_DEF,
    parameter int CODE_WORDS   = sbe_pkg::CODE_WORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [sbe_pkg::W_PLEN-1:0]    i_cfg_data,
    sbe_cmd_if.sink                       i_cmd,
    sbe_res_if.source                     o_res
);
`include "assert_macros.svh"

    localparam int SI  = $clog2(STACK_WORDS);
    localparam int SPW = SI + 1;
    localparam int GI  = (GLOBAL_WORDS > 1) ? $clog2(GLOBAL_WORDS) : 1;
    localparam int WW  = sbe_pkg::W_WORD;

    localparam logic signed [SPW-1:0] SP_EMPTY = '1;
    localparam logic signed [SPW-1:0] SP_ONE   = SPW'(1);
    localparam logic signed [SPW-1:0] SP_TWO   = SPW'(2);
    localparam logic signed [SPW-1:0] SP_THREE = SPW'(3);
    localparam logic signed [SPW-1:0] SP_TOP   = SPW'(STACK_WORDS - 1);
    localparam logic signed [SPW-1:0] SP_CALL  = SPW'(STACK_WORDS - 3);
    localparam logic [WW-1:0]         CODE_LIM = WW'(CODE_WORDS);
    localparam logic [WW-1:0]         GLB_LIM  = WW'(GLOBAL_WORDS);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EXEC, S_W1, S_W2} t_state;

    t_state                       r_state;
    logic [2:0]                   r_k;
    logic [2:0]                   r_nrd;
    logic                         r_rdv;
    logic [1:0]                   r_rdi;
    logic [WW-1:0]                r_d [4];
    logic [sbe_pkg::W_ACTION-1:0] r_op;
    logic [WW-1:0]                r_opnd;
    logic [sbe_pkg::W_ARGC-1:0]   r_argc;
    logic signed [SPW-1:0]        r_sp;
    logic signed [SPW-1:0]        r_fp;
    logic [WW-1:0]                r_ip;
    logic                         r_halt;
    logic [sbe_pkg::W_PLEN-1:0]   r_plen;
    logic                         r_slot_ok;
    logic [SI-1:0]                r_slot;
    logic [SI-1:0]                r_w1a, r_w2a;
    logic [WW-1:0]                r_w1d, r_w2d;
    logic                         r_ov;
    logic [sbe_pkg::W_ADDR-1:0]   r_o_addr;
    logic                         r_o_pv;
    logic [WW-1:0]                r_o_pval;
    logic                         r_o_halt;
    logic [sbe_pkg::W_STATUS-1:0] r_o_st;

    logic                         w_ready, w_acc;
    logic [WW-1:0]                w_limit;
    logic [WW-1:0]                w_srd, w_grd;
    logic [WW-1:0]                w_d [4];
    logic [SI-1:0]                w_raddr;
    logic                         w_we;
    logic [SI-1:0]                w_waddr;
    logic [WW-1:0]                w_wdata;
    logic signed [33:0]           w_slot;
    logic [2:0]                   w_nrd;

    // Results of the execute step.
    logic [sbe_pkg::W_STATUS-1:0] n_st;
    logic [WW-1:0]                n_ip;
    logic signed [SPW-1:0]        n_sp, n_fp;
    logic                         n_halt, n_pv;
    logic [WW-1:0]                n_pval;
    logic                         n_swe, n_gwe;
    logic [SI-1:0]                n_swa;
    logic [WW-1:0]                n_swd;

    logic                         sp_ge0, sp_ge1;
    logic [WW-1:0]                a, b, r;
    logic signed [33:0]           nsp;

    assign w_limit = ({19'd0, r_plen} < CODE_LIM) ? {19'd0, r_plen} : CODE_LIM;
    assign w_ready = (r_state == S_IDLE) && (!r_ov || o_res.ready);
    assign w_acc   = i_cmd.valid && w_ready;
    assign i_cmd.ready = w_ready;

    // Frame slot of an incoming load or store, from the frame pointer held now.
    assign w_slot = 34'(r_fp) + 34'(signed'(i_cmd.first_operand));

    // Stack reads needed before execution.
    always_comb begin
        case (i_cmd.action) inside
            [sbe_pkg::OP_IADD:sbe_pkg::OP_IEQ]: w_nrd = 3'd2;
            sbe_pkg::OP_RET:                    w_nrd = 3'd4;
            sbe_pkg::OP_BRT, sbe_pkg::OP_BRF, sbe_pkg::OP_LOAD, sbe_pkg::OP_GLOAD,
            sbe_pkg::OP_STORE, sbe_pkg::OP_GSTORE, sbe_pkg::OP_PRINT:
                                                w_nrd = 3'd1;
            default:                            w_nrd = 3'd0;
        endcase
    end

    // Read address for read number r_k.
    always_comb begin
        logic signed [SPW-1:0] ad;
        ad = r_sp;
        case (r_op) inside
            [sbe_pkg::OP_IADD:sbe_pkg::OP_IEQ]: ad = (r_k == 3'd0) ? r_sp - SP_ONE : r_sp;
            sbe_pkg::OP_RET: begin
                case (r_k)
                    3'd0:    ad = r_fp - SP_ONE;
                    3'd1:    ad = r_fp - SP_TWO;
                    3'd2:    ad = r_sp;
                    default: ad = r_fp;
                endcase
            end
            default: ad = r_sp;
        endcase
        w_raddr = (r_op == sbe_pkg::OP_LOAD) ? r_slot : ad[SI-1:0];
    end

    // Forward the word arriving this cycle.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_d[i] = (r_rdv && (r_rdi == 2'(i))) ? w_srd : r_d[i];
        end
    end

    // Execute step.
    always_comb begin
        n_st   = sbe_pkg::ST_OK;
        n_sp   = r_sp;
        n_fp   = r_fp;
        n_pv   = 1'b0;
        n_pval = '0;
        n_swe  = 1'b0;
        n_gwe  = 1'b0;
        n_swa  = '0;
        n_swd  = '0;
        n_halt = r_halt;
        sp_ge0 = !r_sp[SPW-1];
        sp_ge1 = sp_ge0 && (r_sp != '0);
        a      = w_d[0];
        b      = w_d[1];
        r      = '0;
        nsp    = 34'(r_fp) - 34'sd3 - 34'(signed'(w_d[1]));
        if (r_op >= sbe_pkg::OP_BR && r_op <= sbe_pkg::OP_GSTORE) n_ip = r_ip + 32'd2;
        else if (r_op == sbe_pkg::OP_CALL)                        n_ip = r_ip + 32'd3;
        else                                                      n_ip = r_ip + 32'd1;
        case (r_op) inside
            [sbe_pkg::OP_IADD:sbe_pkg::OP_IEQ]: begin
                if (!sp_ge1) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else begin
                    case (r_op)
                        sbe_pkg::OP_IADD: r = a + b;
                        sbe_pkg::OP_ISUB: r = a - b;
                        sbe_pkg::OP_IMUL: r = a * b;
                        sbe_pkg::OP_ILT:  r = {31'd0, $signed(a) < $signed(b)};
                        default:          r = {31'd0, a == b};
                    endcase
                    n_swe = 1'b1;
                    n_swa = SI'(r_sp - SP_ONE);
                    n_swd = r;
                    n_sp  = r_sp - SP_ONE;
                end
            end
            sbe_pkg::OP_BR: n_ip = r_opnd;
            sbe_pkg::OP_BRT, sbe_pkg::OP_BRF: begin
                if (!sp_ge0) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else begin
                    n_sp = r_sp - SP_ONE;
                    if ((r_op == sbe_pkg::OP_BRT && a == 32'd1) ||
                        (r_op == sbe_pkg::OP_BRF && a == 32'd0)) begin
                        n_ip = r_opnd;
                    end
                end
            end
            sbe_pkg::OP_ICONST, sbe_pkg::OP_LOAD, sbe_pkg::OP_GLOAD: begin
                if (r_sp == SP_TOP) begin
                    n_st = sbe_pkg::ST_OVER;
                end else if (r_op == sbe_pkg::OP_LOAD && !r_slot_ok) begin
                    n_st = sbe_pkg::ST_SLOT;
                end else if (r_op == sbe_pkg::OP_GLOAD && r_opnd >= GLB_LIM) begin
                    n_st = sbe_pkg::ST_GADDR;
                end else begin
                    n_swe = 1'b1;
                    n_swa = SI'(r_sp + SP_ONE);
                    if (r_op == sbe_pkg::OP_ICONST)    n_swd = r_opnd;
                    else if (r_op == sbe_pkg::OP_LOAD) n_swd = a;
                    else                               n_swd = w_grd;
                    n_sp = r_sp + SP_ONE;
                end
            end
            sbe_pkg::OP_STORE: begin
                if (!sp_ge0) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else if (!r_slot_ok) begin
                    n_st = sbe_pkg::ST_SLOT;
                end else begin
                    n_swe = 1'b1;
                    n_swa = r_slot;
                    n_swd = a;
                    n_sp  = r_sp - SP_ONE;
                end
            end
            sbe_pkg::OP_GSTORE: begin
                if (!sp_ge0) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else if (r_opnd >= GLB_LIM) begin
                    n_st = sbe_pkg::ST_GADDR;
                end else begin
                    n_gwe = 1'b1;
                    n_sp  = r_sp - SP_ONE;
                end
            end
            sbe_pkg::OP_PRINT: begin
                if (!sp_ge0) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else begin
                    n_pv   = 1'b1;
                    n_pval = a;
                    n_sp   = r_sp - SP_ONE;
                end
            end
            sbe_pkg::OP_POP: begin
                if (!sp_ge0) n_st = sbe_pkg::ST_UNDER;
                else         n_sp = r_sp - SP_ONE;
            end
            sbe_pkg::OP_HALT: begin
                n_ip   = r_ip;
                n_halt = 1'b1;
            end
            sbe_pkg::OP_CALL: begin
                if (r_sp >= SP_CALL) begin
                    n_st = sbe_pkg::ST_OVER;
                end else begin
                    n_swe = 1'b1;
                    n_swa = SI'(r_sp + SP_ONE);
                    n_swd = {22'd0, r_argc};
                    n_sp  = r_sp + SP_THREE;
                    n_fp  = r_sp + SP_THREE;
                    n_ip  = r_opnd;
                end
            end
            sbe_pkg::OP_RET: begin
                // Frame words: saved count at fp-2, saved frame at fp-1, return at fp.
                if (!sp_ge0 || r_fp < SP_TWO) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else if ($signed(w_d[0]) < -32'sd1 ||
                             $signed(w_d[0]) >= $signed(WW'(STACK_WORDS))) begin
                    n_st = sbe_pkg::ST_SLOT;
                end else if (nsp < -34'sd1) begin
                    n_st = sbe_pkg::ST_UNDER;
                end else if (nsp >= 34'(STACK_WORDS - 1)) begin
                    n_st = sbe_pkg::ST_OVER;
                end else begin
                    n_swe = 1'b1;
                    n_swa = SI'(nsp + 34'sd1);
                    n_swd = w_d[2];
                    n_sp  = SPW'(nsp + 34'sd1);
                    n_fp  = SPW'(w_d[0]);
                    n_ip  = w_d[3];
                end
            end
            sbe_pkg::OP_INIT: n_st = sbe_pkg::ST_OK;
            default:          n_st = sbe_pkg::ST_BADOP;
        endcase
        if (n_ip >= w_limit) n_halt = 1'b1;
    end

    // Stack write port: execute step, then the two further call words.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = n_swa;
        w_wdata = n_swd;
        if (r_state == S_EXEC) begin
            w_we = n_swe;
        end else if (r_state == S_W1) begin
            w_we    = 1'b1;
            w_waddr = r_w1a;
            w_wdata = r_w1d;
        end else if (r_state == S_W2) begin
            w_we    = 1'b1;
            w_waddr = r_w2a;
            w_wdata = r_w2d;
        end
    end

    sbe_stack_mem #(
        .DEPTH   (STACK_WORDS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_srd)
    );

    sbe_global_mem #(
        .DEPTH   (GLOBAL_WORDS),
        .AW      (GI)
    ) u_global (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    ((r_state == S_EXEC) && n_gwe),
        .i_addr  (r_opnd[GI-1:0]),
        .i_wdata (w_d[0]),
        .o_rdata (w_grd)
    );

    // Sequencer, architectural state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= SP_EMPTY;
            r_fp    <= SP_EMPTY;
            r_ip    <= '0;
            r_halt  <= 1'b0;
            r_plen  <= sbe_pkg::PLEN_RESET;
            r_ov    <= 1'b0;
            r_rdv   <= 1'b0;
            r_k     <= '0;
        end else begin
            r_rdv <= (r_state == S_RD);
            r_rdi <= r_k[1:0];
            if (r_rdv) begin
                r_d[r_rdi] <= w_srd;
            end
            if (r_ov && o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sbe_pkg::CFG_START: r_ip   <= {20'd0, i_cfg_data[sbe_pkg::W_ADDR-1:0]};
                    sbe_pkg::CFG_PLEN:  r_plen <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op      <= i_cmd.action;
                        r_opnd    <= i_cmd.first_operand;
                        r_argc    <= i_cmd.second_operand;
                        r_nrd     <= w_nrd;
                        r_k       <= '0;
                        r_slot_ok <= !w_slot[33] && (w_slot < 34'(STACK_WORDS));
                        r_slot    <= w_slot[SI-1:0];
                        if (r_halt || r_ip >= w_limit) begin
                            // Halted or past the end: report the pointer, execute nothing.
                            r_halt   <= 1'b1;
                            r_ov     <= 1'b1;
                            r_o_addr <= r_ip[sbe_pkg::W_ADDR-1:0];
                            r_o_pv   <= 1'b0;
                            r_o_pval <= '0;
                            r_o_halt <= 1'b1;
                            r_o_st   <= sbe_pkg::ST_OK;
                        end else begin
                            r_state <= (w_nrd == 3'd0) ? S_EXEC : S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == r_nrd - 3'd1) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_sp     <= n_sp;
                    r_fp     <= n_fp;
                    r_ip     <= n_ip;
                    r_halt   <= n_halt;
                    r_ov     <= 1'b1;
                    r_o_addr <= n_ip[sbe_pkg::W_ADDR-1:0];
                    r_o_pv   <= n_pv;
                    r_o_pval <= n_pval;
                    r_o_halt <= n_halt;
                    r_o_st   <= n_st;
                    r_w1a    <= SI'(r_sp + SP_TWO);
                    r_w1d    <= WW'(r_fp);
                    r_w2a    <= SI'(r_sp + SP_THREE);
                    r_w2d    <= r_ip + 32'd3;
                    if (r_op == sbe_pkg::OP_CALL && n_st == sbe_pkg::ST_OK) begin
                        r_state <= S_W1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_W1: r_state <= S_W2;
                S_W2: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.next_address = r_o_addr;
    assign o_res.print_valid  = r_o_pv;
    assign o_res.print_value  = r_o_pval;
    assign o_res.halted       = r_o_halt;
    assign o_res.status       = r_o_st;

    `SBE_ASSERT(a_slot_free, (r_state == S_EXEC) |-> !r_ov, "result slot busy at execute")
    `SBE_ASSERT(a_call_seq, (r_state == S_W1) |=> (r_state == S_W2), "call write sequence broken")
    `SBE_ASSERT(a_halt_sticks, r_halt |=> r_halt, "halt flag cleared")
    `SBE_ASSERT(a_no_accept_busy, (r_state != S_IDLE) |-> !i_cmd.ready, "beat taken while busy")
endmodule

/* verif/sbe_checker.sv */
// Result checker for the stack bytecode executor: tracks the machine state,
// predicts each result beat and compares it. Depends on sbe_pkg and sbe_if.
`timescale 1ns / 1ps
module sbe_checker
    import sbe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [W_PLEN-1:0]   i_cfg_data,
    sbe_cmd_if                  cmd,
    sbe_res_if                  res,
    output int                  o_fails,
    output int                  o_pending,
    output int                  o_stack_top,
    output int                  o_frame_base,
    output logic [31:0]         o_pointer,
    output logic [31:0]         o_return_word,
    output logic [1023:0]       o_written
);
    localparam int SW = STACK_WORDS_DEF;
    localparam int GW = GLOBAL_WORDS_DEF;

    typedef struct packed {
        logic [W_ADDR-1:0]   next_address;
        logic                print_valid;
        logic [W_WORD-1:0]   print_value;
        logic                halted;
        logic [W_STATUS-1:0] status;
    } t_result_beat;

    t_result_beat     expected_beats[$];
    logic [31:0]      stack_mem[SW];
    logic [SW-1:0]    written;
    logic [31:0]      global_mem[GW];
    int               sp;
    int               fp;
    logic [31:0]      ip;
    logic             halt_seen;
    logic [12:0]      plen_reg;
    int               fails;

    task automatic put_word(input longint idx, input logic [31:0] value);
        stack_mem[int'(idx)] = value;
        written[int'(idx)]   = 1'b1;
    endtask

    // Advance the machine by one instruction and build the beat it answers with.
    task automatic execute(input logic [7:0] op, input logic [31:0] opnd,
                           input logic [9:0] argc, output t_result_beat beat);
        logic [31:0] nxt, a, b, r, rv, ra;
        logic [2:0]  st;
        logic        pv;
        logic [31:0] pval;
        longint      slot, nfp, nsp, limit;
        beat = '0;
        st   = ST_OK;
        pv   = 1'b0;
        pval = '0;
        r    = '0;
        limit = (plen_reg < CODE_WORDS_DEF) ? longint'(plen_reg) : longint'(CODE_WORDS_DEF);
        if (halt_seen || longint'(ip) >= limit) begin
            halt_seen         = 1'b1;
            beat.next_address = ip[11:0];
            beat.halted       = 1'b1;
            beat.status       = ST_OK;
            return;
        end
        if (op >= OP_BR && op <= OP_GSTORE) nxt = ip + 32'd2;
        else if (op == OP_CALL) nxt = ip + 32'd3;
        else nxt = ip + 32'd1;
        slot = longint'(fp) + longint'($signed(opnd));
        case (op)
            OP_IADD, OP_ISUB, OP_IMUL, OP_ILT, OP_IEQ: begin
                if (sp < 1) begin
                    st = ST_UNDER;
                end else begin
                    a = stack_mem[sp-1];
                    b = stack_mem[sp];
                    case (op)
                        OP_IADD: r = a + b;
                        OP_ISUB: r = a - b;
                        OP_IMUL: r = a * b;
                        OP_ILT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        default: r = (a == b) ? 32'd1 : 32'd0;
                    endcase
                    put_word(sp - 1, r);
                    sp = sp - 1;
                end
            end
            OP_BR: nxt = opnd;
            OP_BRT, OP_BRF: begin
                if (sp < 0) begin
                    st = ST_UNDER;
                end else begin
                    a  = stack_mem[sp];
                    sp = sp - 1;
                    if ((op == OP_BRT && a == 32'd1) || (op == OP_BRF && a == 32'd0))
                        nxt = opnd;
                end
            end
            OP_ICONST, OP_LOAD, OP_GLOAD: begin
                if (sp + 1 >= SW) st = ST_OVER;
                else if (op == OP_LOAD && (slot < 0 || slot >= SW)) st = ST_SLOT;
                else if (op == OP_GLOAD && opnd >= GW) st = ST_GADDR;
                else begin
                    if (op == OP_ICONST) r = opnd;
                    else if (op == OP_LOAD) r = stack_mem[int'(slot)];
                    else r = global_mem[opnd[7:0]];
                    put_word(sp + 1, r);
                    sp = sp + 1;
                end
            end
            OP_STORE: begin
                if (sp < 0) st = ST_UNDER;
                else if (slot < 0 || slot >= SW) st = ST_SLOT;
                else begin
                    put_word(slot, stack_mem[sp]);
                    sp = sp - 1;
                end
            end
            OP_GSTORE: begin
                if (sp < 0) st = ST_UNDER;
                else if (opnd >= GW) st = ST_GADDR;
                else begin
                    global_mem[opnd[7:0]] = stack_mem[sp];
                    sp = sp - 1;
                end
            end
            OP_PRINT: begin
                if (sp < 0) st = ST_UNDER;
                else begin
                    pv   = 1'b1;
                    pval = stack_mem[sp];
                    sp   = sp - 1;
                end
            end
            OP_POP: begin
                if (sp < 0) st = ST_UNDER;
                else sp = sp - 1;
            end
            OP_HALT: begin
                nxt       = ip;
                halt_seen = 1'b1;
            end
            OP_CALL: begin
                if (sp + 3 >= SW) st = ST_OVER;
                else begin
                    put_word(sp + 1, {22'd0, argc});
                    put_word(sp + 2, fp);
                    put_word(sp + 3, ip + 32'd3);
                    sp  = sp + 3;
                    fp  = sp;
                    nxt = opnd;
                end
            end
            OP_RET: begin
                if (sp < 0 || fp < 2) st = ST_UNDER;
                else begin
                    nfp = longint'($signed(stack_mem[fp-1]));
                    if (nfp < -1 || nfp >= SW) st = ST_SLOT;
                    else begin
                        nsp = longint'(fp) - 3 - longint'($signed(stack_mem[fp-2]));
                        if (nsp < -1) st = ST_UNDER;
                        else if (nsp + 1 >= SW) st = ST_OVER;
                        else begin
                            rv = stack_mem[sp];
                            ra = stack_mem[fp];
                            put_word(nsp + 1, rv);
                            sp  = int'(nsp + 1);
                            fp  = int'(nfp);
                            nxt = ra;
                        end
                    end
                end
            end
            OP_INIT: ;
            default: st = ST_BADOP;
        endcase
        ip = nxt;
        if (longint'(ip) >= limit) halt_seen = 1'b1;
        beat.next_address = ip[11:0];
        beat.print_valid  = pv;
        beat.print_value  = pval;
        beat.halted       = halt_seen;
        beat.status       = st;
    endtask

    // Sample mid-cycle: inputs and outputs only move at rising edges.
    always @(negedge i_clk) begin
        t_result_beat exp_beat, got_beat;
        if (!i_rst_n) begin
            expected_beats.delete();
            written   = '0;
            sp        = -1;
            fp        = -1;
            plen_reg  = PLEN_RESET;
            ip        = '0;
            halt_seen = 1'b0;
            fails     = 0;
            for (int g = 0; g < GW; g++) global_mem[g] = '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_START) begin
                    ip = {20'd0, i_cfg_data[11:0]};
                end else begin
                    plen_reg = i_cfg_data;
                end
            end
            if (cmd.valid && cmd.ready) begin
                execute(cmd.action, cmd.first_operand, cmd.second_operand, exp_beat);
                expected_beats.push_back(exp_beat);
            end
            if (res.valid && res.ready) begin
                got_beat = {res.next_address, res.print_valid, res.print_value,
                            res.halted, res.status};
                if (expected_beats.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("%0t: result beat with nothing pending", $time);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (got_beat !== exp_beat) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: wrong result beat: next %h/%h print %b/%b ",
                                      "value %h/%h halted %b/%b status %0d/%0d (exp/got)"},
                                     $time, exp_beat.next_address, got_beat.next_address,
                                     exp_beat.print_valid, got_beat.print_valid,
                                     exp_beat.print_value, got_beat.print_value,
                                     exp_beat.halted, got_beat.halted,
                                     exp_beat.status, got_beat.status);
                    end
                end
            end
        end
        o_fails       = fails;
        o_pending     = expected_beats.size();
        o_stack_top   = sp;
        o_frame_base  = fp;
        o_pointer     = ip;
        o_written     = written;
        o_return_word = (fp >= 0 && fp < SW && written[fp]) ? stack_mem[fp] : '0;
    end
endmodule

/* verif/testbench.sv */
// Top of the executor testbench: clock, reset, instruction stimulus, result
// back-pressure and the verdict. Depends on sbe_pkg, sbe_if and sbe_checker.
`timescale 1ns / 1ps
module testbench;
    import sbe_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {MIX_TRAFFIC, CALL_HEAVY, DRAIN_HEAVY} t_traffic;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic               cfg_idx;
    logic [W_PLEN-1:0]  cfg_data;

    int                 fails;
    int                 pending;
    int                 sp;
    int                 fp;
    logic [31:0]        ip;
    logic [31:0]        ret_word;
    logic [1023:0]      written;
    int                 cur_plen;
    bit                 wrap_guard;
    int                 idle_cycles;

    sbe_cmd_if cmd ();
    sbe_res_if res ();

    stack_bytecode_executor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd),
        .o_res      (res)
    );

    sbe_checker result_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .cmd           (cmd),
        .res           (res),
        .o_fails       (fails),
        .o_pending     (pending),
        .o_stack_top   (sp),
        .o_frame_base  (fp),
        .o_pointer     (ip),
        .o_return_word (ret_word),
        .o_written     (written)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    initial idle_cycles = 0;
    always @(negedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("stack_bytecode_executor: mismatch");
            $finish;
        end
    end

    // Result side: stall for a random number of cycles before each beat.
    // At least a quarter of the beats go straight through, giving stall-free stretches.
    initial begin
        int stall;
        res.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            // With ready held high, a valid seen mid-cycle is taken at the next edge.
            do @(negedge i_clk); while (!res.valid);
            @(posedge i_clk);
        end
    end

    // An item is safe when it cannot read a stack word that was never written.
    // Also refuse a return whose target would run off the end of the program.
    function automatic bit is_safe(input logic [7:0] op, input logic [31:0] opnd);
        longint slot;
        bit     ok;
        ok   = 1'b1;
        slot = longint'(fp) + longint'($signed(opnd));
        case (op)
            OP_IADD, OP_ISUB, OP_IMUL, OP_ILT, OP_IEQ:
                if (sp >= 1) ok = written[sp] && written[sp-1];
            OP_BRT, OP_BRF, OP_STORE, OP_GSTORE, OP_PRINT:
                if (sp >= 0) ok = written[sp];
            OP_LOAD:
                if (slot >= 0 && slot < STACK_WORDS_DEF) ok = written[int'(slot)];
            OP_RET:
                if (sp >= 0 && fp >= 2)
                    ok = written[sp] && written[fp] && written[fp-1] && written[fp-2]
                         && longint'(ret_word) + 12 < longint'(cur_plen);
            default: ;
        endcase
        return ok;
    endfunction

    // Draw one instruction, weighted by the traffic mix; halt is kept out.
    function automatic void make_item(input t_traffic mode, output logic [7:0] op,
                                      output logic [31:0] opnd, output logic [9:0] argc);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == CALL_HEAVY && roll < 60) begin
            op = OP_CALL;
        end else if (mode == DRAIN_HEAVY && roll < 70) begin
            case ($urandom_range(0, 7))
                0: op = OP_POP;
                1: op = OP_PRINT;
                2: op = OP_GSTORE;
                3: op = OP_RET;
                4: op = OP_BRF;
                5: op = OP_STORE;
                6: op = OP_IADD;
                default: op = OP_IEQ;
            endcase
        end else if (roll >= 88) begin
            op = 8'($urandom_range(0, 255));
        end else begin
            op = 8'($urandom_range(1, 18));
        end
        if (op == OP_HALT) op = OP_INIT;
        case (op)
            OP_BR, OP_BRT, OP_BRF, OP_CALL:
                opnd = $urandom_range(0, cur_plen - 16);
            OP_LOAD, OP_STORE:
                opnd = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 16) - 8 : $urandom;
            OP_GLOAD, OP_GSTORE:
                opnd = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 300) : $urandom;
            OP_ICONST:
                case ($urandom_range(0, 7))
                    0: opnd = 32'h8000_0000;
                    1: opnd = 32'h7fff_ffff;
                    2: opnd = 32'hffff_ffff;
                    3: opnd = 32'd0;
                    4: opnd = $urandom_range(0, 3);
                    default: opnd = $urandom;
                endcase
            default: opnd = $urandom;
        endcase
        argc = ($urandom_range(0, 9) < 6) ? 10'($urandom_range(0, 2))
                                          : 10'($urandom_range(0, 1023));
    endfunction

    // Present one instruction beat after a random gap and hold it until taken.
    task automatic send_item(input logic [7:0] op, input logic [31:0] opnd,
                             input logic [9:0] argc);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        // The checker state now holds every beat taken so far.
        if (!is_safe(op, opnd)) op = OP_INIT;
        if (wrap_guard && longint'(ip) + 12 >= longint'(cur_plen)) begin
            op   = OP_BR;
            opnd = $urandom_range(0, cur_plen / 2);
        end
        cmd.valid          <= 1'b1;
        cmd.action         <= op;
        cmd.first_operand  <= opnd;
        cmd.second_operand <= argc;
        do @(negedge i_clk); while (!cmd.ready);
        @(posedge i_clk);
    endtask

    task automatic run_traffic(input t_traffic mode, input int count);
        logic [7:0]  op;
        logic [31:0] opnd;
        logic [9:0]  argc;
        repeat (count) begin
            make_item(mode, op, opnd, argc);
            send_item(op, opnd, argc);
        end
    endtask

    // Drop valid and hold until every result is back, then let the pipe drain.
    task automatic settle();
        cmd.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [W_PLEN-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_program(input int start, input int plen);
        write_reg(CFG_START, W_PLEN'(start));
        write_reg(CFG_PLEN, W_PLEN'(plen));
        cur_plen = plen;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_START;
        cfg_data           <= '0;
        cmd.valid          <= 1'b0;
        cmd.action         <= OP_INIT;
        cmd.first_operand  <= '0;
        cmd.second_operand <= '0;
        cur_plen   = 4096;
        wrap_guard = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: run from the reset pointer through every opcode class but halt.
        send_item(OP_POP,    0, 0);               // pop on empty stack
        send_item(OP_IADD,   0, 0);               // arithmetic underflow
        send_item(OP_ICONST, 32'h7fff_ffff, 0);
        send_item(OP_ICONST, 1, 0);
        send_item(OP_IADD,   0, 0);               // wraps to the most negative word
        send_item(OP_ICONST, 32'hffff_ffff, 0);
        send_item(OP_IMUL,   0, 0);
        send_item(OP_ICONST, 5, 0);
        send_item(OP_ILT,    0, 0);               // signed compare gives true
        send_item(OP_BRT,    40, 0);              // taken
        send_item(OP_ICONST, 0, 0);
        send_item(OP_BRF,    60, 0);              // taken
        send_item(OP_ICONST, 3, 0);
        send_item(OP_ICONST, 3, 0);
        send_item(OP_IEQ,    0, 0);
        send_item(OP_GSTORE, 255, 0);             // top global word
        send_item(OP_GLOAD,  255, 0);
        send_item(OP_GSTORE, 256, 0);             // just past the global store
        send_item(OP_GLOAD,  32'hffff_ffff, 0);   // huge global address
        send_item(OP_ISUB,   0, 0);               // one word only: underflow
        send_item(OP_PRINT,  0, 0);
        send_item(OP_CALL,   100, 0);
        send_item(OP_ICONST, 9, 0);
        send_item(OP_STORE,  1, 0);               // slot just above the frame base
        send_item(OP_LOAD,   1, 0);
        send_item(OP_LOAD,   32'hffff_ec78, 0);   // frame slot below the stack
        send_item(OP_RET,    0, 0);
        send_item(8'd0,      0, 0);               // invalid opcodes at both ends
        send_item(8'd255,    0, 0);
        send_item(OP_BR,     8, 0);

        settle();
        set_program($urandom_range(0, 1000), 4096);
        run_traffic(MIX_TRAFFIC, 500);

        // Start at address zero and push frames with call-heavy traffic.
        settle();
        set_program(0, $urandom_range(2000, 4095));
        run_traffic(CALL_HEAVY, 400);

        settle();
        set_program($urandom_range(0, 2000), 4096);
        run_traffic(DRAIN_HEAVY, 400);

        settle();
        set_program($urandom_range(0, 1500), $urandom_range(2000, 4096));
        run_traffic(MIX_TRAFFIC, 400);

        // Halt for real, then park the pointer at the last word with no program.
        send_item(OP_HALT, 0, 0);
        wrap_guard = 1'b0;
        run_traffic(MIX_TRAFFIC, 3);
        settle();
        set_program(4095, 0);
        run_traffic(MIX_TRAFFIC, 4);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("stack_bytecode_executor: match");
        else
            $display("stack_bytecode_executor: mismatch");
        $finish;
    end
endmodule
